// ===== src/qcsv_pkg.sv =====
package qcsv_pkg;

  localparam int unsigned VOLT_W     = 15;
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned MARGIN_W   = 12;
  localparam int unsigned STEP_W     = 12;
  localparam int unsigned AUX_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SCALE_W    = 10;
  localparam int unsigned PROD_W     = 26;
  localparam int unsigned DIV_STEPS  = PROD_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [SCALE_W-1:0] BUDGET_SCALE = SCALE_W'(1000);
  localparam logic [FIELD_W-1:0] BASE_MV      = FIELD_W'(5000);
  localparam logic [VOLT_W-1:0]  FIX_5V_MV    = VOLT_W'(5000);
  localparam logic [VOLT_W-1:0]  FIX_9V_MV    = VOLT_W'(9000);
  localparam logic [VOLT_W-1:0]  FIX_12V_MV   = VOLT_W'(12000);
  localparam logic [VOLT_W-1:0]  FIX_20V_MV   = VOLT_W'(20000);
  localparam logic [AUX_W-1:0]   AUX_FALLBACK = AUX_W'(0);
  localparam logic [AUX_W-1:0]   AUX_NORMAL   = AUX_W'(10);
  localparam logic [FIELD_W-1:0] CUR_SAT      = '1;

  typedef enum logic [2:0] {
    ACT_ATTACH    = 3'd0,
    ACT_DETACH    = 3'd1,
    ACT_DCP       = 3'd2,
    ACT_HVDCP     = 3'd3,
    ACT_FIXED     = 3'd4,
    ACT_PULSE_UP  = 3'd5,
    ACT_PULSE_DN  = 3'd6,
    ACT_SCP_OUT   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    MODE_NONE  = 3'd0,
    MODE_5V    = 3'd1,
    MODE_9V    = 3'd2,
    MODE_12V   = 3'd3,
    MODE_20V   = 3'd4,
    MODE_CONT  = 3'd5,
    MODE_RSV6  = 3'd6,
    MODE_RSV7  = 3'd7
  } qc_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUDGET   = 3'd0,
    REG_CAP      = 3'd1,
    REG_MARGIN   = 3'd2,
    REG_STEP     = 3'd3,
    REG_CEILING  = 3'd4,
    REG_FLOOR    = 3'd5,
    REG_FALLBACK = 3'd6,
    REG_UNUSED   = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  power_budget_mw;
    logic [FIELD_W-1:0]  current_cap_ma;
    logic [MARGIN_W-1:0] current_margin_ma;
    logic [STEP_W-1:0]   step_mv;
    logic [VOLT_W-1:0]   ceiling_mv;
    logic [VOLT_W-1:0]   floor_mv;
    logic [FIELD_W-1:0]  fallback_current_ma;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ===== src/qc_source_voltage_current_manager_unit.sv =====
// Quick Charge source-side voltage/current manager.
//
// Input channel (in_*): one negotiation event per transfer; the action code
// rides on in_tuser, the remaining event fields on in_tdata. Output channel
// (out_*): exactly one result transfer per event, carrying the issue flag,
// bus voltage, current limit, aux code and the PD-blocked flag.
// Configuration: write cfg_wdata into register cfg_index when cfg_wr_en is
// high; index 7 is ignored. Write only while no event is in flight.
//
// Sequencing: events that need no current limit go from accept straight to
// ST_DONE for result loading. Events that issue a computed limit pass ST_MUL,
// which starts the restoring divider on budget times 1000 (registered while
// idle), ST_DIV (one quotient bit per cycle), ST_FIN for clamp and margin add
// and ST_DONE for result loading. A zero voltage skips the divider.
// Throughput: one event at a time; in_tready is high only while idle, but
// a new event is accepted while the previous result still waits at out_*.
// Reset: requested voltage returns to 5000 mV, the protocol flag clears,
// registers return to their defaults and the output register empties.
// Stall: a result holds in the output register until out_tready; a finished
// event waits in ST_DONE before loading, and no further event is accepted.
module qc_source_voltage_current_manager_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata, low bit up: qc_mode[2:0], pd_connected, pd_supply_mv[15:0],
  // scp_vout_mv[15:0], scp_iout_ma[15:0], zero pad[3:0]
  input  logic [qcsv_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: action[2:0]
  input  logic [2:0]                        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata, low bit up: issue, bus_volt_mv[15:0], bus_current_ma[15:0],
  // aux_code[3:0], pd_blocked, zero pad[1:0]
  output logic [qcsv_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic [qcsv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qcsv_pkg::FIELD_W-1:0]      cfg_wdata
);
  import qcsv_pkg::*;

  cfg_t     cfg;
  logic     div_start, div_busy, div_done;
  logic [PROD_W-1:0] div_q;

  state_t state_r, state_nxt;

  // architectural state
  logic [VOLT_W-1:0] req_volt_r, req_volt_nxt;
  logic              entered_r, entered_nxt;

  // pending result
  logic              res_issue_r, res_issue_nxt;
  logic [FIELD_W-1:0] res_volt_r, res_volt_nxt;
  logic [FIELD_W-1:0] res_cur_r, res_cur_nxt;
  logic [AUX_W-1:0]  res_aux_r, res_aux_nxt;
  logic              res_blk_r, res_blk_nxt;
  logic              need_cur, zero_volt_r;

  logic [PROD_W-1:0] prod_r;

  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_valid_r;

  logic in_fire, load_out;

  // event fields
  action_t           act;
  qc_mode_t          mode;
  logic              pd_conn;
  logic [FIELD_W-1:0] pd_mv, scp_v, scp_i;
  logic              pd_owns;

  // pulse arithmetic
  logic [FIELD_W-1:0] up_sum, dn_thr;
  logic [VOLT_W-1:0]  pulse_volt;

  // clamp and margin
  logic [FIELD_W-1:0] cur_clamped;
  logic [FIELD_W:0]   cur_sum;
  logic [FIELD_W-1:0] cur_final;

  qcsv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  qcsv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (res_volt_r[VOLT_W-1:0]),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign act     = action_t'(in_tuser);
  assign mode    = qc_mode_t'(in_tdata[2:0]);
  assign pd_conn = in_tdata[3];
  assign pd_mv   = in_tdata[19:4];
  assign scp_v   = in_tdata[35:20];
  assign scp_i   = in_tdata[51:36];
  assign pd_owns = pd_conn && (pd_mv != BASE_MV);

  assign in_fire = in_tvalid && in_tready;

  // pulse up saturates at the ceiling; pulse down snaps to the floor
  always_comb begin
    up_sum = FIELD_W'(req_volt_r) + FIELD_W'(cfg.step_mv);
    dn_thr = FIELD_W'(cfg.floor_mv) + FIELD_W'(cfg.step_mv);
    if (act == ACT_PULSE_UP) begin
      pulse_volt = (up_sum >= FIELD_W'(cfg.ceiling_mv)) ? cfg.ceiling_mv
                                                       : up_sum[VOLT_W-1:0];
    end else begin
      pulse_volt = (FIELD_W'(req_volt_r) <= dn_thr) ? cfg.floor_mv
                 : VOLT_W'(req_volt_r - VOLT_W'(cfg.step_mv));
    end
  end

  // decode an accepted event into new state and a pending result
  always_comb begin
    req_volt_nxt  = req_volt_r;
    entered_nxt   = entered_r;
    res_issue_nxt = 1'b0;
    res_volt_nxt  = '0;
    res_cur_nxt   = '0;
    res_aux_nxt   = '0;
    res_blk_nxt   = 1'b0;
    need_cur      = 1'b0;
    unique case (act)
      ACT_ATTACH, ACT_DETACH: begin
        entered_nxt = 1'b0;
      end
      ACT_DCP, ACT_HVDCP: begin
        if (entered_r) begin
          res_issue_nxt = 1'b1;
          res_volt_nxt  = BASE_MV;
          res_cur_nxt   = cfg.fallback_current_ma;
          res_aux_nxt   = AUX_FALLBACK;
        end
      end
      ACT_FIXED: begin
        entered_nxt = 1'b1;
        if (pd_owns) begin
          res_blk_nxt = 1'b1;
        end else begin
          unique case (mode)
            MODE_5V:  req_volt_nxt = FIX_5V_MV;
            MODE_9V:  req_volt_nxt = FIX_9V_MV;
            MODE_12V: req_volt_nxt = FIX_12V_MV;
            MODE_20V: req_volt_nxt = FIX_20V_MV;
            default:  req_volt_nxt = req_volt_r;
          endcase
          res_issue_nxt = 1'b1;
          res_volt_nxt  = FIELD_W'(req_volt_nxt);
          res_aux_nxt   = AUX_NORMAL;
          need_cur      = 1'b1;
        end
      end
      ACT_PULSE_UP, ACT_PULSE_DN: begin
        // the pulse counts on arrival, even when PD refuses it
        req_volt_nxt = pulse_volt;
        entered_nxt  = 1'b1;
        if (pd_owns) begin
          res_blk_nxt = 1'b1;
        end else if (mode == MODE_CONT) begin
          res_issue_nxt = 1'b1;
          res_volt_nxt  = FIELD_W'(pulse_volt);
          res_aux_nxt   = AUX_NORMAL;
          need_cur      = 1'b1;
        end
      end
      ACT_SCP_OUT: begin
        entered_nxt   = 1'b1;
        res_issue_nxt = 1'b1;
        res_volt_nxt  = scp_v;
        res_cur_nxt   = scp_i;
        res_aux_nxt   = AUX_NORMAL;
      end
      default: ;
    endcase
  end

  // clamp the quotient to the cap (the cap alone for a zero voltage), add the margin, saturate at full scale
  always_comb begin
    if (zero_volt_r || (div_q > PROD_W'(cfg.current_cap_ma))) begin
      cur_clamped = cfg.current_cap_ma;
    end else begin
      cur_clamped = div_q[FIELD_W-1:0];
    end
    cur_sum   = {1'b0, cur_clamped} + (FIELD_W+1)'(cfg.current_margin_ma);
    cur_final = cur_sum[FIELD_W] ? CUR_SAT : cur_sum[FIELD_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!need_cur)                state_nxt = ST_DONE;
          else if (res_volt_nxt == '0)  state_nxt = ST_FIN;
          else                          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_MUL:  div_start = 1'b1;
      ST_DONE: load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      req_volt_r  <= FIX_5V_MV;
      entered_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        req_volt_r <= req_volt_nxt;
        entered_r  <= entered_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_issue_r <= res_issue_nxt;
      res_volt_r  <= res_volt_nxt;
      res_cur_r   <= res_cur_nxt;
      res_aux_r   <= res_aux_nxt;
      res_blk_r   <= res_blk_nxt;
      zero_volt_r <= (res_volt_nxt == '0);
    end else if (state_r == ST_FIN) begin
      res_cur_r <= cur_final;
    end
    if (state_r == ST_IDLE) begin
      prod_r <= PROD_W'(cfg.power_budget_mw) * PROD_W'(BUDGET_SCALE);
    end
    if (load_out) begin
      out_data_r <= {2'b00, res_blk_r, res_aux_r, res_cur_r, res_volt_r, res_issue_r};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

`ifndef SYNTH
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == ST_DIV))
    else $error("divider busy outside the divide phase");

  a_div_done_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (div_done && state_r == ST_DIV) |=> (state_r == ST_FIN))
    else $error("divider result not taken");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared without a finished event");

  a_issue_xor_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[37]))
    else $error("result both issued and refused");
`endif

endmodule

// ===== src/qcsv_cfg.sv =====
module qcsv_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [qcsv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qcsv_pkg::FIELD_W-1:0]  cfg_wdata,
  output qcsv_pkg::cfg_t                cfg_o
);
  import qcsv_pkg::*;

  cfg_t cfg_r;

  assign cfg_o = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_budget_mw     <= FIELD_W'(18000);
      cfg_r.current_cap_ma      <= FIELD_W'(3000);
      cfg_r.current_margin_ma   <= MARGIN_W'(300);
      cfg_r.step_mv             <= STEP_W'(200);
      cfg_r.ceiling_mv          <= VOLT_W'(12000);
      cfg_r.floor_mv            <= VOLT_W'(5000);
      cfg_r.fallback_current_ma <= FIELD_W'(3500);
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BUDGET:   cfg_r.power_budget_mw     <= cfg_wdata;
        REG_CAP:      cfg_r.current_cap_ma      <= cfg_wdata;
        REG_MARGIN:   cfg_r.current_margin_ma   <= cfg_wdata[MARGIN_W-1:0];
        REG_STEP:     cfg_r.step_mv             <= cfg_wdata[STEP_W-1:0];
        REG_CEILING:  cfg_r.ceiling_mv          <= cfg_wdata[VOLT_W-1:0];
        REG_FLOOR:    cfg_r.floor_mv            <= cfg_wdata[VOLT_W-1:0];
        REG_FALLBACK: cfg_r.fallback_current_ma <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/qcsv_div.sv =====
module qcsv_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [qcsv_pkg::PROD_W-1:0] dividend,
  input  logic [qcsv_pkg::VOLT_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [qcsv_pkg::PROD_W-1:0] quotient
);
  import qcsv_pkg::*;

  logic [VOLT_W-1:0]    rem_r, rem_nxt;
  logic [VOLT_W-1:0]    dvs_r;
  logic [PROD_W-1:0]    quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [VOLT_W:0]      trial;
  logic                 ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[PROD_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? VOLT_W'(trial - {1'b0, dvs_r}) : trial[VOLT_W-1:0];
    quo_nxt = {quo_r[PROD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule
